### src/assert_macros.svh
// Assertion macros shared by the deframer modules.
// Each macro samples on the rising edge of clk and is quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define MSRD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define MSRD_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### src/msrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msrd_pkg;

    // Frame opening bytes.
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    // Function codes with a known frame layout.
    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_READ_INPUT   = 8'h04;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

    // Frame positions.
    localparam logic [8:0] POS_FUNC_CODE  = 9'd6;
    localparam logic [8:0] END_POS_ERROR  = 9'd9;
    localparam logic [8:0] END_POS_WRITE  = 9'd12;
    localparam logic [8:0] END_POS_READ0  = 9'd9;
    localparam logic [8:0] POS_FIRST_CRC  = 9'd2;

    // Modbus CRC-16 constants.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [1:0] {
        KIND_READ         = 2'd0,
        KIND_WRITE_SINGLE = 2'd1,
        KIND_WRITE_MULTI  = 2'd2,
        KIND_UNKNOWN      = 2'd3
    } frame_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_HDR  = 2'd1,
        ST_LEN  = 2'd2,
        ST_BODY = 2'd3
    } parse_state_t;

    // Everything reported for one received byte.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        in_frame;
        logic [8:0]  frame_pos;
        logic        frame_done;
        logic        crc_ok;
        frame_kind_t frame_kind;
        logic [7:0]  func_code;
        logic [31:0] crc_error_total;
        logic [31:0] func_error_total;
    } result_t;

    // One byte through the reflected CRC-16, eight shift steps.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

    // Frame layout class of a function code.
    function automatic frame_kind_t kind_of(input logic [7:0] fc);
        frame_kind_t kind;
        case (fc)
            FC_READ_HOLDING, FC_READ_INPUT: kind = KIND_READ;
            FC_WRITE_SINGLE:                kind = KIND_WRITE_SINGLE;
            FC_WRITE_MULTI:                 kind = KIND_WRITE_MULTI;
            default:                        kind = KIND_UNKNOWN;
        endcase
        return kind;
    endfunction

endpackage

`default_nettype wire

### src/msrd_parser.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module msrd_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic [7:0]       rx_byte,
    output msrd_pkg::result_t     result
);
    import msrd_pkg::*;

    parse_state_t state_reg, state_next;
    logic         start_reg, start_next;
    logic [8:0]   idx_reg, idx_next;
    logic [8:0]   end_reg, end_next;
    logic [7:0]   fc_reg, fc_next;
    logic         known_reg, known_next;
    logic [15:0]  crc_reg, crc_next;
    logic [7:0]   tail0_reg, tail0_next;
    logic [7:0]   tail1_reg, tail1_next;
    logic [31:0]  crc_cnt_reg, crc_cnt_next;
    logic [31:0]  fn_cnt_reg, fn_cnt_next;

    logic         taken;
    logic [8:0]   pos;
    logic         done;
    logic         ok;
    logic [15:0]  crc_fed;
    logic         at_end;

    // The CRC trails the input by two bytes, so the oldest tail byte is folded in.
    assign crc_fed = crc_feed(crc_reg, tail0_reg);
    assign at_end  = (idx_reg >= end_reg);

    // Next parse state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (rx_byte == BYTE_LF && rx_byte != BYTE_CR && start_reg)
                    state_next = ST_HDR;
            end
            ST_HDR:
            begin
                if (idx_reg >= POS_FUNC_CODE)
                begin
                    if (kind_of(rx_byte) == KIND_READ)
                        state_next = ST_LEN;
                    else
                        state_next = ST_BODY;
                end
            end
            ST_LEN:
            begin
                state_next = ST_BODY;
            end
            ST_BODY:
            begin
                if (at_end)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and per-byte flags.
    always_comb
    begin
        start_next   = start_reg;
        idx_next     = idx_reg;
        end_next     = end_reg;
        fc_next      = fc_reg;
        known_next   = known_reg;
        crc_next     = crc_reg;
        tail0_next   = tail0_reg;
        tail1_next   = tail1_reg;
        crc_cnt_next = crc_cnt_reg;
        fn_cnt_next  = fn_cnt_reg;
        taken        = 1'b0;
        pos          = '0;
        done         = 1'b0;
        ok           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (rx_byte == BYTE_CR)
                begin
                    // A carriage return always restarts the opening.
                    crc_next   = CRC_INIT;
                    tail0_next = 8'h00;
                    tail1_next = rx_byte;
                    fc_next    = 8'h00;
                    known_next = 1'b0;
                    start_next = 1'b1;
                    idx_next   = 9'd1;
                    taken      = 1'b1;
                end
                else if (rx_byte == BYTE_LF && start_reg)
                begin
                    tail0_next = tail1_reg;
                    tail1_next = rx_byte;
                    start_next = 1'b0;
                    idx_next   = 9'd2;
                    taken      = 1'b1;
                    pos        = 9'd1;
                end
                else
                begin
                    start_next = 1'b0;
                end
            end
            default:
            begin
                pos        = idx_reg;
                taken      = 1'b1;
                crc_next   = crc_fed;
                tail0_next = tail1_reg;
                tail1_next = rx_byte;
                case (state_reg)
                    ST_HDR:
                    begin
                        if (idx_reg >= POS_FUNC_CODE)
                        begin
                            fc_next    = rx_byte;
                            known_next = 1'b1;
                            case (kind_of(rx_byte))
                                KIND_READ:    end_next = end_reg;
                                KIND_UNKNOWN: end_next = END_POS_ERROR;
                                default:      end_next = END_POS_WRITE;
                            endcase
                        end
                    end
                    ST_LEN:
                    begin
                        end_next = END_POS_READ0 + {1'b0, rx_byte};
                    end
                    default:
                    begin
                        if (at_end)
                        begin
                            // Last byte: trailing pair, high byte first, against the CRC.
                            done       = 1'b1;
                            ok         = ({tail1_reg, rx_byte} == crc_fed);
                            start_next = 1'b0;
                            if (!ok)
                                crc_cnt_next = crc_cnt_reg + 32'd1;
                            if (kind_of(fc_reg) == KIND_UNKNOWN)
                                fn_cnt_next = fn_cnt_reg + 32'd1;
                        end
                    end
                endcase
                idx_next = done ? 9'd0 : idx_reg + 9'd1;
            end
        endcase
    end

    // Result for the byte in the input register.
    always_comb
    begin
        result.data_byte        = rx_byte;
        result.in_frame         = taken;
        result.frame_pos        = pos;
        result.frame_done       = done;
        result.crc_ok           = ok;
        result.frame_kind       = known_next ? kind_of(fc_next) : KIND_READ;
        result.func_code        = known_next ? fc_next : 8'h00;
        result.crc_error_total  = crc_cnt_next;
        result.func_error_total = fn_cnt_next;
    end

    // Parser state moves only when the byte goes on to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            idx_reg     <= '0;
            end_reg     <= '0;
            fc_reg      <= '0;
            known_reg   <= 1'b0;
            crc_reg     <= CRC_INIT;
            tail0_reg   <= '0;
            tail1_reg   <= '0;
            crc_cnt_reg <= '0;
            fn_cnt_reg  <= '0;
        end
        else if (advance)
        begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            idx_reg     <= idx_next;
            end_reg     <= end_next;
            fc_reg      <= fc_next;
            known_reg   <= known_next;
            crc_reg     <= crc_next;
            tail0_reg   <= tail0_next;
            tail1_reg   <= tail1_next;
            crc_cnt_reg <= crc_cnt_next;
            fn_cnt_reg  <= fn_cnt_next;
        end
    end

    // A frame body is only reached after its function code.
    `MSRD_ASSERT(a_body_has_code, (state_reg != ST_BODY) || known_reg, "body without code")
    // The position never runs past the end of the frame.
    `MSRD_ASSERT(a_body_in_range, (state_reg != ST_BODY) || (idx_reg <= end_reg), "pos overrun")
    // The CRC error count moves only on a finished frame with a bad CRC.
    `MSRD_ASSERT_NEXT(a_crc_cnt_hold, !(advance && result.frame_done && !result.crc_ok),
        crc_cnt_reg == $past(crc_cnt_reg), "crc error count moved without a bad frame")

endmodule

`default_nettype wire

### src/modbus_style_response_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Response deframer: takes one received byte per item and returns one result per byte,
// with its frame position, frame-done and CRC flags, the frame kind and function code,
// and the running CRC and function error counts. A byte may be accepted every cycle
// while the result side does not stall; it is held in the input register and its
// result is loaded into the result register once that register is free, from which
// it is offered. The path between the two registers is one byte of the CRC-16 (eight
// shift steps) plus the frame-length compare. Frames open with 0x0D 0x0A seen while idle.
module modbus_style_response_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        rx_valid,
    output logic             rx_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [7:0]       data_byte,
    output logic             in_frame,
    output logic [8:0]       frame_pos,
    output logic             frame_done,
    output logic             crc_ok,
    output logic [1:0]       frame_kind,
    output logic [7:0]       func_code,
    output logic [31:0]      crc_error_total,
    output logic [31:0]      func_error_total
);
    import msrd_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg;
    result_t    out_result_reg;
    result_t    result;
    logic       out_free;
    logic       advance;
    logic       accept;

    // Handshake between the input register and the result register.
    assign out_free = !out_valid_reg || !result_stall;
    assign advance  = s1_valid_reg && out_free;
    assign rx_stall = s1_valid_reg && !out_free;
    assign accept   = rx_valid && !rx_stall;

    msrd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rx_byte (s1_byte_reg),
        .result  (result)
    );

    // Valid flags of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_byte_reg <= rx_byte;
        if (advance)
            out_result_reg <= result;
    end

    // Output ports.
    assign result_valid     = out_valid_reg;
    assign data_byte        = out_result_reg.data_byte;
    assign in_frame         = out_result_reg.in_frame;
    assign frame_pos        = out_result_reg.frame_pos;
    assign frame_done       = out_result_reg.frame_done;
    assign crc_ok           = out_result_reg.crc_ok;
    assign frame_kind       = out_result_reg.frame_kind;
    assign func_code        = out_result_reg.func_code;
    assign crc_error_total  = out_result_reg.crc_error_total;
    assign func_error_total = out_result_reg.func_error_total;

    // Upstream is held back only while a byte waits in the input register.
    `MSRD_ASSERT(a_stall_needs_item, !rx_stall || s1_valid_reg, "stall with empty input stage")
    // A finished frame always ends on a byte that belongs to it.
    `MSRD_ASSERT(a_done_in_frame, !(result_valid && frame_done) || in_frame, "done outside frame")
    // A good CRC is reported only on the last byte of a frame.
    `MSRD_ASSERT(a_ok_with_done, !(result_valid && crc_ok) || frame_done, "crc_ok without done")

endmodule

`default_nettype wire
